@@ rtl/core/restoring_divider_u32_unit_assert.svh @@
// Assertion macros used by the restoring divider top level.
`ifndef RESTORING_DIVIDER_U32_UNIT_ASSERT_SVH
`define RESTORING_DIVIDER_U32_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RDU32_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("restoring divider assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RDU32_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("restoring divider assertion failed");

`endif

@@ rtl/core/rdu32_pkg.sv @@
// Package with the transaction types and constants of the restoring divider.
package rdu32_pkg;

   localparam int FIELD_WIDTH        = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] dividend_in;
      logic [FIELD_WIDTH-1:0] divisor_in;
   } rdu32_req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] quotient_out;
      logic [FIELD_WIDTH-1:0] remainder_out;
      logic                   divide_by_zero;
   } rdu32_rsp_type;

endpackage

@@ rtl/core/rdu32_stage.sv @@
// One pipeline stage of the restoring divider: a single shift and trial subtraction.
module rdu32_stage #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_dvd,
   input  logic [DATA_WIDTH-1:0] in_dvs,
   input  logic [DATA_WIDTH-1:0] in_quo,
   input  logic                  in_dbz,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_dvd,
   output logic [DATA_WIDTH-1:0] out_dvs,
   output logic [DATA_WIDTH-1:0] out_quo,
   output logic                  out_dbz
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] dvd_ff;
   logic [DATA_WIDTH-1:0] dvd_in;
   logic [DATA_WIDTH-1:0] dvs_ff;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] quo_in;
   logic                  dbz_ff;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   trial;
   logic                  load;

   // The stage holds only when it carries a transaction the next stage refuses.
   assign in_stall = valid_ff && out_stall;
   assign load     = in_valid && !in_stall;

   // The bit shifted out of the partial remainder makes the trial one bit wider.
   always_comb begin
      shifted = {in_rem[DATA_WIDTH-2:0], in_dvd[DATA_WIDTH-1]};
      trial   = {in_rem[DATA_WIDTH-1], shifted} - {1'b0, in_dvs};
      dvd_in  = {in_dvd[DATA_WIDTH-2:0], 1'b0};
      if (trial[DATA_WIDTH]) begin
         rem_in = shifted;
         quo_in = {in_quo[DATA_WIDTH-2:0], 1'b0};
      end else begin
         rem_in = trial[DATA_WIDTH-1:0];
         quo_in = {in_quo[DATA_WIDTH-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         dvs_ff <= in_dvs;
         quo_ff <= quo_in;
         dbz_ff <= in_dbz;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dvd   = dvd_ff;
   assign out_dvs   = dvs_ff;
   assign out_quo   = quo_ff;
   assign out_dbz   = dbz_ff;

endmodule

@@ rtl/core/restoring_divider_u32_unit.sv @@
// Top level of the pipelined unsigned restoring divider.
//
// Usage: a division request is a transaction on the req_ channel carrying the
// dividend and divisor; each one yields exactly one transaction on the rsp_
// channel with quotient, remainder and a divide-by-zero flag, in request order.
// A zero divisor gives quotient and remainder of zero with the flag set.
// Operands are taken as DATA_WIDTH bits wide; results keep their low 32 bits.
// Each accepted request passes through DATA_WIDTH pipeline stages, one per
// quotient bit, and a new request is accepted every cycle while req_stall is low.
// Throughput is one transaction per cycle while rsp_stall stays low.
// When the receiver stalls, the result holds in the last stage and stages
// behind it keep filling empty slots; req_stall rises only when the transaction
// in the first stage cannot move on. Reset empties every stage; no result is
// presented until a new request has passed through all DATA_WIDTH stages.
module restoring_divider_u32_unit #(
   parameter int DATA_WIDTH = rdu32_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rdu32_pkg::rdu32_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rdu32_pkg::rdu32_rsp_type rsp_data
);

   import rdu32_pkg::*;

   `include "restoring_divider_u32_unit_assert.svh"

   logic                  valid_s [0:DATA_WIDTH];
   logic                  stall_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dvd_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dvs_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_s   [0:DATA_WIDTH];
   logic                  dbz_s   [0:DATA_WIDTH];

   assign valid_s[0] = req_valid;
   assign rem_s[0]   = '0;
   assign dvd_s[0]   = DATA_WIDTH'(req_data.dividend_in);
   assign dvs_s[0]   = DATA_WIDTH'(req_data.divisor_in);
   assign quo_s[0]   = '0;
   assign dbz_s[0]   = (DATA_WIDTH'(req_data.divisor_in) == '0);
   assign req_stall  = stall_s[0];

   for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_stage
      rdu32_stage #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_s[g]),
         .in_stall (stall_s[g]),
         .in_rem   (rem_s[g]),
         .in_dvd   (dvd_s[g]),
         .in_dvs   (dvs_s[g]),
         .in_quo   (quo_s[g]),
         .in_dbz   (dbz_s[g]),
         .out_valid(valid_s[g+1]),
         .out_stall(stall_s[g+1]),
         .out_rem  (rem_s[g+1]),
         .out_dvd  (dvd_s[g+1]),
         .out_dvs  (dvs_s[g+1]),
         .out_quo  (quo_s[g+1]),
         .out_dbz  (dbz_s[g+1])
      );
   end

   assign stall_s[DATA_WIDTH] = rsp_stall;
   assign rsp_valid           = valid_s[DATA_WIDTH];

   always_comb begin
      if (dbz_s[DATA_WIDTH]) begin
         rsp_data.quotient_out  = '0;
         rsp_data.remainder_out = '0;
      end else begin
         rsp_data.quotient_out  = FIELD_WIDTH'(quo_s[DATA_WIDTH]);
         rsp_data.remainder_out = FIELD_WIDTH'(rem_s[DATA_WIDTH]);
      end
      rsp_data.divide_by_zero = dbz_s[DATA_WIDTH];
   end

   `RDU32_ASSERT_IMPLIES(a_dbz_zero_result, clock, reset,
      rsp_valid && rsp_data.divide_by_zero,
      rsp_data.quotient_out == '0 && rsp_data.remainder_out == '0)
   `RDU32_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset,
      rsp_valid && !dbz_s[DATA_WIDTH], rem_s[DATA_WIDTH] < dvs_s[DATA_WIDTH])
   `RDU32_ASSERT_IMPLIES(a_stall_from_output, clock, reset,
      req_stall, rsp_valid && rsp_stall)
   `RDU32_ASSERT_NEXT(a_accept_enters_stage, clock, reset,
      req_valid && !req_stall, valid_s[1])

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the pipelined unsigned restoring divider.
class division_checker;
   localparam int DW = rdu32_pkg::DATA_WIDTH_DEFAULT;

   rdu32_pkg::rdu32_rsp_type awaited_results[$];
   int mismatches = 0;

   function automatic rdu32_pkg::rdu32_rsp_type divide_restoring(
      rdu32_pkg::rdu32_req_type req);
      logic [DW-1:0]  dvd;
      logic [DW-1:0]  dvs;
      logic [DW-1:0]  rem;
      logic [DW-1:0]  quo;
      logic [DW:0]    trial;
      rdu32_pkg::rdu32_rsp_type res;
      int             i;
      dvd = req.dividend_in[DW-1:0];
      dvs = req.divisor_in[DW-1:0];
      res = '0;
      if (dvs == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      rem = '0;
      quo = '0;
      for (i = DW - 1; i >= 0; i--) begin
         // The trial subtraction is one bit wider so that the bit shifted out is kept.
         trial = {rem, dvd[i]} - {1'b0, dvs};
         if (!trial[DW]) begin
            rem    = trial[DW-1:0];
            quo[i] = 1'b1;
         end else begin
            rem = {rem[DW-2:0], dvd[i]};
         end
      end
      res.quotient_out  = quo;
      res.remainder_out = rem;
      return res;
   endfunction

   function void note_division(rdu32_pkg::rdu32_req_type req);
      awaited_results.push_back(divide_restoring(req));
   endfunction

   function void check_division(rdu32_pkg::rdu32_rsp_type got);
      rdu32_pkg::rdu32_rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: quotient %0h remainder %0h flag %0b",
                got.quotient_out, got.remainder_out, got.divide_by_zero);
         mismatches++;
         return;
      end
      want = awaited_results.pop_front();
      if (got.quotient_out !== want.quotient_out) begin
         $error("quotient_out: expected %0h, actual %0h",
                want.quotient_out, got.quotient_out);
         mismatches++;
      end
      if (got.remainder_out !== want.remainder_out) begin
         $error("remainder_out: expected %0h, actual %0h",
                want.remainder_out, got.remainder_out);
         mismatches++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
         $error("divide_by_zero: expected %0b, actual %0b",
                want.divide_by_zero, got.divide_by_zero);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   import rdu32_pkg::*;

   localparam int HOLD_CYCLES = 200;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   rdu32_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rdu32_rsp_type rsp_data;

   bit idling_on    = 1'b1;
   bit hold_request = 1'b0;

   division_checker div_check = new();

   restoring_divider_u32_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #800000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         div_check.note_division(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         div_check.check_division(rsp_data);
      end
   end

   // The receiver stalls at random while idling_on is set or, on request, holds off for a long stretch.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(0, 99) < 25);
         end
      end
   end

   task automatic send_req(input logic [31:0] dividend, input logic [31:0] divisor);
      while (idling_on && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{dividend_in: dividend, divisor_in: divisor};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (div_check.awaited_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 15);
         1:       return 32'h8000_0000 | $urandom;
         2:       return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [31:0] dividend;
      logic [31:0] divisor;
      for (int n = 0; n < count; n++) begin
         dividend = random_operand();
         divisor  = ($urandom_range(0, 99) < 3) ? 32'h0 : random_operand();
         if ($urandom_range(0, 9) == 0) begin
            divisor = dividend + $urandom_range(0, 2) - 1;
         end
         send_req(dividend, divisor);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_req(32'h0000_0000, 32'h0000_0000);
      send_req(32'h0000_0001, 32'h0000_0000);
      send_req(32'hFFFF_FFFF, 32'h0000_0000);
      send_req(32'h0000_0000, 32'h0000_0001);
      send_req(32'hFFFF_FFFF, 32'h0000_0001);
      send_req(32'h0000_0001, 32'h0000_0001);
      send_req(32'h0000_0000, 32'hFFFF_FFFF);
      send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_req(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_req(32'h8000_0000, 32'h8000_0000);
      send_req(32'h8000_0000, 32'hFFFF_FFFF);
      send_req(32'hFFFF_FFFF, 32'h8000_0000);
      send_req(32'hFFFF_FFFF, 32'h8000_0001);
      send_req(32'h7FFF_FFFF, 32'h8000_0000);
      send_req(32'hFFFF_FFFF, 32'h0000_0002);
      send_req(32'h1234_5678, 32'h0000_0001);
      send_req(32'd100,       32'd7);
      send_req(32'd5,         32'd7);
      send_req(32'd123456789, 32'd3);
      wait_for_results();

      send_random(600);

      idling_on = 1'b0;
      send_random(300);

      hold_request = 1'b1;
      send_random(100);
      idling_on = 1'b1;

      wait_for_results();
      send_random(800);

      wait_for_results();
      repeat (u_top.DATA_WIDTH + 8) @(negedge clock);

      if (div_check.awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", div_check.awaited_results.size());
         div_check.mismatches++;
      end
      if (div_check.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rdu32_pkg.sv
rtl/core/rdu32_stage.sv
rtl/core/restoring_divider_u32_unit.sv
test/tb_top.sv
